// File: hw/rtl/lis_pkg.sv
`default_nettype none

package lis_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_VALUE_BITS = 32;

	localparam int ELEM_W      = 32;
	localparam int LEN_W       = 7;
	localparam int M_TDATA_W   = 40;

	// handoff from the trace walk to the result stage
	typedef struct packed {
		logic             start;
		logic             ovf;
		logic [LEN_W-1:0] length;
	} emit_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/longest_increasing_subsequence_top.sv
`default_nettype none
// the scan of an item reads one stored entry per cycle from the element memory, so it takes
//   longer the more entries are stored, and then drains the compare stage
// the closing item then walks the predecessor chain, one read state and one write state per
//   element; the result stage reads and loads each beat, reading the next while m_tready holds the last
// reset clears counters, flags and handshakes; memory contents are left as they are

module longest_increasing_subsequence_top #(
	parameter int CAPACITY   = lis_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = lis_pkg::DEF_VALUE_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// value [VALUE_BITS-1:0], zero pad up to a whole byte
	input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,
	input  wire logic                                s_tlast,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// element [31:0], length [38:32], zero pad [39]
	output logic [lis_pkg::M_TDATA_W-1:0]            m_tdata,
	output logic                                     m_tlast,
	// overflowed [0]
	output logic                                     m_tuser
);

	localparam int IW  = $clog2(CAPACITY);       // entry index
	localparam int LW  = $clog2(CAPACITY + 1);   // counts and run lengths
	localparam int MW  = VALUE_BITS + LW + IW;   // element memory word

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN     = 6'b000010,
		ST_WRITE    = 6'b000100,
		ST_TRACE_RD = 6'b001000,
		ST_TRACE_WR = 6'b010000,
		ST_EMIT     = 6'b100000
	} state_t;

	state_t               state_q;

	// element memory: {value, run length, predecessor} per entry
	logic [MW-1:0]        elem_mem [CAPACITY];
	logic [MW-1:0]        rdata_q;
	logic [IW-1:0]        rd_addr;
	logic                 mem_we;
	logic [MW-1:0]        wdata;

	logic [VALUE_BITS-1:0] rd_val;
	logic [LW-1:0]        rd_len;
	logic [IW-1:0]        rd_pred;

	// sequence state
	logic [LW-1:0]        cnt_q;
	logic                 ovf_q;
	logic [LW-1:0]        best_len_q;
	logic [IW-1:0]        best_at_q;

	// current item
	logic [VALUE_BITS-1:0] v_q;
	logic                 last_q;

	// scan
	logic [LW-1:0]        j_q;
	logic                 rd_vld_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic [LW-1:0]        cand_len_q;
	logic [IW-1:0]        cand_pred_q;
	logic                 hit;

	// write-back and running best
	logic [LW-1:0]        new_len;
	logic [LW-1:0]        best_len_nx;
	logic [IW-1:0]        best_at_nx;

	// trace walk
	logic [IW-1:0]        pos_q;
	logic [LW-1:0]        k_q;
	logic                 buf_we;
	logic [IW-1:0]        buf_addr;
	logic [VALUE_BITS:0]  buf_data;

	lis_pkg::emit_cmd_t   emit_cmd;
	logic                 emit_done;

	assign s_tready = (state_q == ST_IDLE);

	assign rd_val  = rdata_q[MW-1 -: VALUE_BITS];
	assign rd_len  = rdata_q[IW +: LW];
	assign rd_pred = rdata_q[IW-1:0];

	// one read port shared by the scan and the trace walk
	always_comb begin
		rd_addr = j_q[IW-1:0];
		if (state_q == ST_TRACE_RD) begin
			rd_addr = pos_q;
		end
	end

	assign new_len = cand_len_q + 1'b1;
	assign mem_we  = (state_q == ST_WRITE);
	assign wdata   = {v_q, new_len, cand_pred_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			elem_mem[cnt_q[IW-1:0]] <= wdata;
		end
		rdata_q <= elem_mem[rd_addr];
	end

	// strictly smaller earlier element with a longer run; first one wins ties
	assign hit = rd_vld_s1 && ($signed(rd_val) < $signed(v_q)) && (rd_len > cand_len_q);

	// first index with the greatest run length, kept as entries are written
	always_comb begin
		best_len_nx = best_len_q;
		best_at_nx  = best_at_q;
		if (new_len > best_len_q) begin
			best_len_nx = new_len;
			best_at_nx  = cnt_q[IW-1:0];
		end
	end

	// trace fills the result buffer back to front, end mark on the chosen entry
	assign buf_we   = (state_q == ST_TRACE_WR);
	assign buf_addr = IW'(k_q - 1'b1);
	assign buf_data = {(k_q == best_len_q), rd_val};

	assign emit_cmd.start  = (state_q == ST_TRACE_WR) && (k_q == LW'(1));
	assign emit_cmd.ovf    = ovf_q;
	assign emit_cmd.length = lis_pkg::LEN_W'(best_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			best_len_q <= '0;
			best_at_q  <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (cnt_q < LW'(CAPACITY)) begin
							state_q <= ST_SCAN;
						end else begin
							// store full: drop the beat, a closing beat still ends the run
							ovf_q   <= 1'b1;
							state_q <= s_tlast ? ST_TRACE_RD : ST_IDLE;
						end
					end
					rd_vld_s1 <= 1'b0;
				end
				ST_SCAN: begin
					rd_vld_s1 <= (j_q < cnt_q);
					if (!(j_q < cnt_q) && !rd_vld_s1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					cnt_q      <= cnt_q + 1'b1;
					best_len_q <= best_len_nx;
					best_at_q  <= best_at_nx;
					state_q    <= last_q ? ST_TRACE_RD : ST_IDLE;
				end
				ST_TRACE_RD: begin
					state_q <= ST_TRACE_WR;
				end
				ST_TRACE_WR: begin
					state_q <= (k_q == LW'(1)) ? ST_EMIT : ST_TRACE_RD;
				end
				ST_EMIT: begin
					// last beat is being loaded into the out register: clear for the next sequence
					if (emit_done) begin
						cnt_q      <= '0;
						ovf_q      <= 1'b0;
						best_len_q <= '0;
						best_at_q  <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					v_q         <= s_tdata[VALUE_BITS-1:0];
					last_q      <= s_tlast;
					j_q         <= '0;
					cand_len_q  <= '0;
					cand_pred_q <= '0;
					pos_q       <= best_at_q;
					k_q         <= best_len_q;
				end
			end
			ST_SCAN: begin
				if (j_q < cnt_q) begin
					j_q <= j_q + 1'b1;
				end
				rd_idx_s1 <= j_q[IW-1:0];
				if (hit) begin
					cand_len_q  <= rd_len;
					cand_pred_q <= rd_idx_s1;
				end
			end
			ST_WRITE: begin
				pos_q <= best_at_nx;
				k_q   <= best_len_nx;
			end
			ST_TRACE_WR: begin
				pos_q <= rd_pred;
				k_q   <= k_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	lis_out #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (buf_we),
		.wr_addr  (buf_addr),
		.wr_data  (buf_data),
		.cmd      (emit_cmd),
		.done     (emit_done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// File: hw/rtl/lis_out.sv
`default_nettype none

module lis_out #(
	parameter int CAPACITY   = lis_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = lis_pkg::DEF_VALUE_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(CAPACITY)-1:0]    wr_addr,
	input  wire logic [VALUE_BITS:0]            wr_data,   // {end mark, value}
	input  wire lis_pkg::emit_cmd_t             cmd,
	output logic                                done,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// element [31:0], length [38:32], zero pad [39]
	output logic [lis_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                m_tlast,
	// overflowed [0]
	output logic                                m_tuser
);

	localparam int IW    = $clog2(CAPACITY);
	localparam int EXT_W = (VALUE_BITS > lis_pkg::ELEM_W) ? VALUE_BITS : lis_pkg::ELEM_W;

	typedef enum logic [2:0] {
		O_IDLE = 3'b001,
		O_RD   = 3'b010,
		O_LD   = 3'b100
	} ostate_t;

	ostate_t                     state_q;
	logic [VALUE_BITS:0]         buf_mem [CAPACITY];
	logic [VALUE_BITS:0]         rdata_q;
	logic [IW-1:0]               e_q;
	logic [lis_pkg::LEN_W-1:0]   len_q;
	logic                        ovf_q;
	logic [EXT_W-1:0]            elem_ext;
	logic                        rd_end;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_mem[wr_addr] <= wr_data;
		end
		rdata_q <= buf_mem[e_q];
	end

	assign elem_ext = EXT_W'(rdata_q[VALUE_BITS-1:0]);
	assign rd_end   = rdata_q[VALUE_BITS];
	assign done     = (state_q == O_LD) && rd_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= O_IDLE;
			m_tvalid <= 1'b0;
			e_q      <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				O_IDLE: begin
					if (cmd.start) begin
						e_q     <= '0;
						state_q <= O_RD;
					end
				end
				O_RD: begin
					// out register is free by the next edge
					if (!m_tvalid || m_tready) begin
						state_q <= O_LD;
					end
				end
				O_LD: begin
					m_tvalid <= 1'b1;
					e_q      <= e_q + 1'b1;
					state_q  <= rd_end ? O_IDLE : O_RD;
				end
				default: state_q <= O_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == O_IDLE && cmd.start) begin
			len_q <= cmd.length;
			ovf_q <= cmd.ovf;
		end
		if (state_q == O_LD) begin
			m_tdata <= {1'b0, len_q, elem_ext[lis_pkg::ELEM_W-1:0]};
			m_tlast <= rd_end;
			m_tuser <= ovf_q;
		end
	end

endmodule

`default_nettype wire
